// ----- hdl/rgb_hex_command_parser_core_assert.svh -----
// ----------------------------------------------------------------------------
// RGB hex command parser assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_HEX_COMMAND_PARSER_CORE_ASSERT_SVH
`define RGB_HEX_COMMAND_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define RHCP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhcp assertion failed");

`define RHCP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhcp assertion failed");

`else

`define RHCP_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define RHCP_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/rhcp_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB hex command parser package
// Frame constants, command and status codes, and the hex digit decoder.
// ----------------------------------------------------------------------------
package rhcp_pkg;

   localparam int FRAME_LENGTH = 10;
   localparam int NIB_COUNT    = FRAME_LENGTH - 3;
   localparam int NIB_IDX_W    = $clog2(NIB_COUNT);
   localparam int POS_W        = $clog2(FRAME_LENGTH);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] CH_START   = 8'h70;
   localparam logic [7:0] CH_WRITE   = 8'h77;
   localparam logic [7:0] CH_INIT    = 8'h69;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic CSR_DEVICE_ID    = 1'b0;
   localparam logic CSR_PROGRAM_MODE = 1'b1;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_INIT,
      CMD_OTHER
   } cmd_type;

   typedef enum logic [2:0] {
      ST_APPLIED  = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_REFUSED  = 3'd2,
      ST_ACCEPTED = 3'd3,
      ST_UNKNOWN  = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] id;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_state_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] val;
      val = 8'd0;
      if (ch >= CH_0 && ch <= CH_9) begin
         val = ch - CH_0;
      end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
         val = ch - CH_UPPER_A + 8'd10;
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
         val = ch - CH_LOWER_A + 8'd10;
      end
      return val[3:0];
   endfunction

endpackage

// ----- hdl/rhcp_front.sv -----
// ----------------------------------------------------------------------------
// RGB hex command parser front end
// Gathers bytes into frames, decodes hex digits and queues whole frames.
// ----------------------------------------------------------------------------
module rhcp_front
   import rhcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_rx_byte,
   input  queue_state_type q_state,
   output logic            push,
   output frame_type       push_frame
);

   localparam logic [POS_W-1:0] POS_CMD  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);
   localparam logic [POS_W-1:0] POS_NIB0 = POS_W'(2);

   logic [POS_W-1:0] pos_ff, pos_in;
   cmd_type          cmd_ff, cmd_in;
   logic [3:0]       nib_ff [NIB_COUNT];
   logic             accept;
   logic [3:0]       nib;
   logic [POS_W-1:0] nib_pos;
   logic [NIB_IDX_W-1:0] nib_idx;

   assign req_stall = q_state.full;
   assign accept    = req_valid & ~req_stall;
   assign nib       = hex_nibble(req_rx_byte);
   assign nib_pos   = pos_ff - POS_NIB0;
   assign nib_idx   = nib_pos[NIB_IDX_W-1:0];
   assign push      = accept && (pos_ff == POS_LAST);

   assign push_frame.cmd   = cmd_ff;
   assign push_frame.red   = {nib_ff[0], nib_ff[1]};
   assign push_frame.green = {nib_ff[2], nib_ff[3]};
   assign push_frame.blue  = {nib_ff[4], nib_ff[5]};
   assign push_frame.id    = {nib_ff[6], nib};

   always_comb begin
      pos_in = pos_ff;
      cmd_in = cmd_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            if (req_rx_byte == CH_START) begin
               pos_in = POS_CMD;
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         if (pos_ff == POS_CMD) begin
            unique case (req_rx_byte)
               CH_WRITE: cmd_in = CMD_WRITE;
               CH_INIT:  cmd_in = CMD_INIT;
               default:  cmd_in = CMD_OTHER;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (accept && pos_ff >= POS_NIB0 && pos_ff != POS_LAST) begin
         nib_ff[nib_idx] <= nib;
      end
   end

endmodule

// ----- hdl/rhcp_queue.sv -----
// ----------------------------------------------------------------------------
// RGB hex command parser frame queue
// Short first-in first-out store of decoded frames between front and back.
// ----------------------------------------------------------------------------
module rhcp_queue
   import rhcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  frame_type       push_frame,
   input  logic            pop,
   output frame_type       pop_frame,
   output queue_state_type q_state
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   frame_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign pop_frame     = mem_ff[rd_ptr_ff];
   assign q_state.full  = (count_ff == CNT_FULL);
   assign q_state.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ----- hdl/rhcp_back.sv -----
// ----------------------------------------------------------------------------
// RGB hex command parser back end
// Executes queued frames, holds the colour levels and the result register.
// ----------------------------------------------------------------------------
module rhcp_back
   import rhcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [7:0]      csr_wdata,
   input  queue_state_type q_state,
   input  frame_type       pop_frame,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_red_compare,
   output logic [7:0]      rsp_green_compare,
   output logic [7:0]      rsp_blue_compare
);

   logic [7:0] device_id_ff, device_id_in;
   logic       program_mode_ff, program_mode_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;

   assign csr_ready         = 1'b1;
   assign pop               = ~q_state.empty & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_red_compare   = ~red_ff;
   assign rsp_green_compare = ~green_ff;
   assign rsp_blue_compare  = ~blue_ff;

   always_comb begin
      device_id_in    = device_id_ff;
      program_mode_in = program_mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEVICE_ID:    device_id_in    = csr_wdata;
            CSR_PROGRAM_MODE: program_mode_in = csr_wdata[0];
            default:          device_id_in    = device_id_ff;
         endcase
      end
   end

   always_comb begin
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
         unique case (pop_frame.cmd)
            CMD_WRITE: begin
               if (pop_frame.id == device_id_ff) begin
                  red_in    = pop_frame.red;
                  green_in  = pop_frame.green;
                  blue_in   = pop_frame.blue;
                  status_in = ST_APPLIED;
               end else begin
                  status_in = ST_MISMATCH;
               end
            end
            CMD_INIT: status_in = program_mode_ff ? ST_ACCEPTED : ST_REFUSED;
            default:  status_in = ST_UNKNOWN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff    <= '0;
         program_mode_ff <= 1'b0;
         red_ff          <= '0;
         green_ff        <= '0;
         blue_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         device_id_ff    <= device_id_in;
         program_mode_ff <= program_mode_in;
         red_ff          <= red_in;
         green_ff        <= green_in;
         blue_ff         <= blue_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

endmodule

// ----- hdl/rgb_hex_command_parser_core.sv -----
// ----------------------------------------------------------------------------
// RGB hex command parser core
// Assembles ten-character lamp command frames and reports colour results.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle while req_stall is low. Bytes
// outside a frame other than 'p' are dropped. The tenth byte of a frame moves
// the decoded frame into a two-word queue; the back end takes one word per
// cycle while no stalled result is held on rsp_, and each result is registered
// before it shows there. The input stalls only when the queue is full, which
// happens only while rsp_stall is held. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`include "rgb_hex_command_parser_core_assert.svh"

module rgb_hex_command_parser_core
   import rhcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_red_compare,
   output logic [7:0] rsp_green_compare,
   output logic [7:0] rsp_blue_compare
);

   queue_state_type q_state;
   logic            push;
   logic            pop;
   frame_type       push_frame;
   frame_type       pop_frame;

   rhcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_state     (q_state),
      .push        (push),
      .push_frame  (push_frame)
   );

   rhcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .q_state    (q_state)
   );

   rhcp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_state           (q_state),
      .pop_frame         (pop_frame),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_red_compare   (rsp_red_compare),
      .rsp_green_compare (rsp_green_compare),
      .rsp_blue_compare  (rsp_blue_compare)
   );

   `RHCP_ASSERT_IMP(a_pop_not_empty, clock, reset, pop, !q_state.empty)
   `RHCP_ASSERT_IMP(a_no_push_full, clock, reset, q_state.full, !push)
   `RHCP_ASSERT_NXT(a_pop_gives_rsp, clock, reset, pop, rsp_valid)

endmodule

// ----- verif/rgb_hex_command_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// RGB hex command parser core testbench
// Streams command bytes into the parser, predicts each frame's status and PWM
// compare values in a scoreboard, and checks every result word in order.
// Runs directed frames, then random frames and noise under several register
// settings and handshake idling profiles.
// ----------------------------------------------------------------------------
module rgb_hex_command_parser_core_tb;
   import rhcp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 4;
   localparam int PHASES       = 6;
   localparam int PHASE_BYTES  = 65;

   typedef struct packed {
      status_type status;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } lamp_result_type;

   class frame_scoreboard;
      logic [7:0]      device_id;
      logic            program_mode;
      int unsigned     position;
      logic [7:0]      chars [FRAME_LENGTH];
      logic [7:0]      red_level;
      logic [7:0]      green_level;
      logic [7:0]      blue_level;
      lamp_result_type pending_results [$];
      int              errors;
      int              taken;
      int              dropped;
      int              tally [5];

      function new();
         device_id    = 8'd0;
         program_mode = 1'b0;
         position     = 0;
         red_level    = 8'd0;
         green_level  = 8'd0;
         blue_level   = 8'd0;
         errors       = 0;
         taken        = 0;
         dropped      = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void set_register(input logic idx, input logic [7:0] data);
         if (idx == CSR_DEVICE_ID) begin
            device_id = data;
         end else begin
            program_mode = data[0];
         end
      endfunction

      function logic [3:0] digit(input logic [7:0] c);
         if (c >= CH_0 && c <= CH_9) return c[3:0];
         if (c >= CH_UPPER_A && c <= CH_UPPER_F) return c[3:0] + 4'd9;
         if (c >= CH_LOWER_A && c <= CH_LOWER_F) return c[3:0] + 4'd9;
         return 4'd0;
      endfunction

      function logic [7:0] pair(input int at);
         return {digit(chars[at]), digit(chars[at + 1])};
      endfunction

      function bit note_byte(input logic [7:0] b);
         lamp_result_type r;
         if (position == 0 && b != CH_START) begin
            dropped++;
            return 1'b0;
         end
         taken++;
         chars[position] = b;
         position++;
         if (position < FRAME_LENGTH) return 1'b1;
         position = 0;
         case (chars[1])
            CH_WRITE: begin
               if (pair(8) != device_id) begin
                  r.status = ST_MISMATCH;
               end else begin
                  red_level   = pair(2);
                  green_level = pair(4);
                  blue_level  = pair(6);
                  r.status    = ST_APPLIED;
               end
            end
            CH_INIT: r.status = program_mode ? ST_ACCEPTED : ST_REFUSED;
            default: r.status = ST_UNKNOWN;
         endcase
         r.red   = 8'hFF - red_level;
         r.green = 8'hFF - green_level;
         r.blue  = 8'hFF - blue_level;
         pending_results.push_back(r);
         tally[r.status]++;
         return 1'b1;
      endfunction

      function void check_result(input logic [2:0] st, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
         lamp_result_type e;
         if (pending_results.size() == 0) begin
            $error("result word with no frame pending: status %0d", st);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (st != e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
         end
         if (r != e.red) begin
            $error("red_compare: expected %0d, got %0d", e.red, r);
            errors++;
         end
         if (g != e.green) begin
            $error("green_compare: expected %0d, got %0d", e.green, g);
            errors++;
         end
         if (b != e.blue) begin
            $error("blue_compare: expected %0d, got %0d", e.blue, b);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_status;
   logic [7:0] rsp_red_compare;
   logic [7:0] rsp_green_compare;
   logic [7:0] rsp_blue_compare;

   frame_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int cycles;

   rgb_hex_command_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_red_compare   (rsp_red_compare),
      .rsp_green_compare (rsp_green_compare),
      .rsp_blue_compare  (rsp_blue_compare)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_status, rsp_red_compare, rsp_green_compare,
                         rsp_blue_compare);
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_byte(b));
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_0 + n;
      return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + n - 8'd10;
   endfunction

   function automatic logic [7:0] frame_digit(input logic [3:0] n);
      if ($urandom_range(99) < 12) return 8'($urandom_range(255));
      return hex_char(n);
   endfunction

   task automatic send_random_frame();
      logic [7:0] id;
      int         pick;
      pick = $urandom_range(99);
      id   = ($urandom_range(99) < 60) ? sb.device_id : 8'($urandom_range(255));
      send_byte(CH_START);
      if (pick < 50) begin
         send_byte(CH_WRITE);
      end else if (pick < 75) begin
         send_byte(CH_INIT);
      end else begin
         send_byte(8'($urandom_range(255)));
      end
      repeat (6) send_byte(frame_digit(4'($urandom_range(15))));
      send_byte(frame_digit(id[7:4]));
      send_byte(frame_digit(id[3:0]));
   endtask

   task automatic write_settings(input logic [7:0] id, input logic [7:0] mode);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEVICE_ID;
      csr_wdata <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_DEVICE_ID, id);
      csr_index <= CSR_PROGRAM_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_PROGRAM_MODE, mode);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   logic [7:0] phase_id   [PHASES] = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h00};
   logic       phase_mode [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

   initial begin
      string      colour_digits;
      string      init_digits;
      logic [7:0] noise;
      int         pick;
      int         target;

      sb            = new();
      cycles        = 0;
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = CSR_DEVICE_ID;
      csr_wdata     = 8'd0;
      req_valid     = 1'b0;
      req_rx_byte   = 8'd0;
      rsp_stall     = 1'b0;
      send_idle_pct = 12;
      recv_idle_pct = 70;
      colour_digits = "f/A:9@00";
      init_digits   = "FFffFF12";

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drop bytes outside a frame, then apply a colour and refuse an init
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_START);
      send_byte(CH_WRITE);
      for (int i = 0; i < colour_digits.len(); i++) send_byte(colour_digits[i]);
      send_byte(CH_START);
      send_byte(CH_INIT);
      for (int i = 0; i < init_digits.len(); i++) send_byte(init_digits[i]);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 12;
            recv_idle_pct = 70;
         end else if (p < 4) begin
            send_idle_pct = 70;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 2 || p == 5) phase_id[p] = 8'($urandom_range(255));
         write_settings(phase_id[p], {7'($urandom_range(127)), phase_mode[p]});
         target = sb.taken + PHASE_BYTES;
         while (sb.taken < target) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               do noise = 8'($urandom_range(255)); while (noise == CH_START);
               send_byte(noise);
            end else if (pick < 25) begin
               send_byte(CH_START);
               repeat (FRAME_LENGTH - 1) send_byte(8'($urandom_range(255)));
            end else begin
               send_random_frame();
            end
         end
         drain();
      end

      $display("%0d bytes taken into frames, %0d bytes dropped, over %0d settings",
               sb.taken, sb.dropped, PHASES + 1);
      $display("frames: %0d applied, %0d id mismatch, %0d init refused, %0d %s",
               sb.tally[ST_APPLIED], sb.tally[ST_MISMATCH], sb.tally[ST_REFUSED],
               sb.tally[ST_ACCEPTED], "init accepted");
      $display("        %0d unknown", sb.tally[ST_UNKNOWN]);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rhcp_pkg.sv
hdl/rhcp_front.sv
hdl/rhcp_queue.sv
hdl/rhcp_back.sv
hdl/rgb_hex_command_parser_core.sv
verif/rgb_hex_command_parser_core_tb.sv
